// ===== design/datetime_to_bcd_rtc_registers_macros.svh =====
// Assertion helpers shared by the RTL that carries checks.
`ifndef DATETIME_TO_BCD_RTC_REGISTERS_MACROS_SVH
`define DATETIME_TO_BCD_RTC_REGISTERS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTB_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTB_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dtb_pkg.sv =====
package dtb_pkg;

    // Register map of the clock chip
    localparam int          NUM_REGS  = 7;
    localparam logic [2:0]  ADDR_SEC  = 3'd0;
    localparam logic [2:0]  ADDR_MIN  = 3'd1;
    localparam logic [2:0]  ADDR_HOUR = 3'd2;
    localparam logic [2:0]  ADDR_WDAY = 3'd3;
    localparam logic [2:0]  ADDR_DAY  = 3'd4;
    localparam logic [2:0]  ADDR_MON  = 3'd5;
    localparam logic [2:0]  ADDR_YEAR = 3'd6;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Valid input ranges
    localparam logic [6:0]  SEC_MAX    = 7'd59;
    localparam logic [6:0]  MIN_MAX    = 7'd59;
    localparam logic [6:0]  HOUR_MAX   = 7'd24;
    localparam logic [6:0]  DAY_MIN    = 7'd1;
    localparam logic [6:0]  DAY_MAX    = 7'd31;
    localparam logic [3:0]  MON_MIN    = 4'd1;
    localparam logic [3:0]  MON_MAX    = 4'd12;
    localparam logic [3:0]  MON_MARCH  = 4'd3;
    localparam logic [11:0] YEAR_MIN   = 12'd2000;
    localparam logic [11:0] YEAR_UPPER = 12'd2100;
    localparam logic [11:0] YEAR_MAX   = 12'd2199;

    // Century flag in the month byte
    localparam logic [7:0] CENTURY_FLAG = 8'b1000_0000;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Input item, seconds in the low bits
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [6:0]  mday;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
    } dtb_in_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic                          err;
        logic [NUM_REGS-1:0][7:0]      bytes;
    } dtb_rec_t;

    // One register write on the result side
    typedef struct packed {
        logic       status;
        logic       last;
        logic [7:0] reg_data;
        logic [2:0] reg_address;
    } dtb_beat_t;

    // Month offsets of the weekday formula
    function automatic logic [2:0] month_offset(input logic [3:0] mon);
        logic [2:0] off;
        case (mon)
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // Binary to two-digit BCD by shift and add-3, one input bit a step
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [7:0] b;
        b = 8'd0;
        for (int i = 6; i >= 0; i--) begin
            if (b[3:0] >= 4'd5) begin
                b[3:0] = b[3:0] + 4'd3;
            end
            if (b[7:4] >= 4'd5) begin
                b[7:4] = b[7:4] + 4'd3;
            end
            b = {b[6:0], v[i]};
        end
        return b;
    endfunction

endpackage

// ===== design/dtb_front.sv =====
module dtb_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  dtb_pkg::dtb_in_t in_data,
    output logic             rec_valid,
    input  logic             rec_ready,
    output dtb_pkg::dtb_rec_t rec_data
);
    import dtb_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_err_reg, s1_err_next;
    logic        s1_upper_reg, s1_upper_next;
    logic [11:0] s1_sum_reg, s1_sum_next;
    logic [6:0]  s1_yy_reg, s1_yy_next;
    dtb_in_t     s1_in_reg, s1_in_next;

    logic        load;
    logic        ok;
    logic [11:0] y_adj;
    logic [11:0] cent;
    logic [11:0] quad;
    logic [11:0] yy_full;
    logic [4:0]  oct_sum;
    logic [3:0]  oct_fold;
    logic [3:0]  rem7;

    // Take a new item whenever the stage is empty or drains this cycle
    assign in_ready = !s1_valid_reg || rec_ready;
    assign load     = in_valid && in_ready;

    // Range checks
    always_comb begin
        ok = (in_data.seconds inside {[7'd0 : SEC_MAX]})
          && (in_data.minutes inside {[7'd0 : MIN_MAX]})
          && (in_data.hours inside {[7'd0 : HOUR_MAX]})
          && (in_data.mday inside {[DAY_MIN : DAY_MAX]})
          && (in_data.month inside {[MON_MIN : MON_MAX]})
          && (in_data.year inside {[YEAR_MIN : YEAR_MAX]});
    end

    // Weekday raw sum: January and February count in the previous year
    always_comb begin
        y_adj = (in_data.month < MON_MARCH) ? in_data.year - 12'd1 : in_data.year;
        if (y_adj >= YEAR_UPPER) begin
            cent = YEAR_UPPER / 12'd100;
        end else if (y_adj >= YEAR_MIN) begin
            cent = YEAR_MIN / 12'd100;
        end else begin
            cent = YEAR_MIN / 12'd100 - 12'd1;
        end
        quad = (y_adj >= YEAR_MIN) ? YEAR_MIN / 12'd400 : YEAR_MIN / 12'd400 - 12'd1;
        s1_sum_next = y_adj + {2'b00, y_adj[11:2]} + quad - cent
                    + {9'd0, month_offset(in_data.month)}
                    + {5'd0, in_data.mday};
    end

    // Two-digit year and century flag
    always_comb begin
        s1_upper_next = in_data.year >= YEAR_UPPER;
        yy_full       = s1_upper_next ? in_data.year - YEAR_UPPER : in_data.year - YEAR_MIN;
        s1_yy_next    = yy_full[6:0];
    end

    // Stage register next values
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_err_next   = s1_err_reg;
        s1_in_next    = s1_in_reg;
        if (load) begin
            s1_valid_next = 1'b1;
            s1_err_next   = !ok;
            s1_in_next    = in_data;
        end else if (rec_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_err_reg <= s1_err_next;
        s1_in_reg  <= s1_in_next;
        if (load) begin
            s1_sum_reg   <= s1_sum_next;
            s1_yy_reg    <= s1_yy_next;
            s1_upper_reg <= s1_upper_next;
        end
    end

    // Sum mod 7: fold octal digits, since 8 is 1 mod 7
    always_comb begin
        oct_sum  = {2'b00, s1_sum_reg[2:0]} + {2'b00, s1_sum_reg[5:3]}
                 + {2'b00, s1_sum_reg[8:6]} + {2'b00, s1_sum_reg[11:9]};
        oct_fold = {1'b0, oct_sum[2:0]} + {2'b00, oct_sum[4:3]};
        rem7     = (oct_fold >= 4'd7) ? oct_fold - 4'd7 : oct_fold;
    end

    // Build the register bytes
    always_comb begin
        rec_data.err             = s1_err_reg;
        rec_data.bytes[ADDR_SEC]  = to_bcd(s1_in_reg.seconds);
        rec_data.bytes[ADDR_MIN]  = to_bcd(s1_in_reg.minutes);
        rec_data.bytes[ADDR_HOUR] = to_bcd(s1_in_reg.hours);
        rec_data.bytes[ADDR_WDAY] = {4'd0, rem7} + 8'd1;
        rec_data.bytes[ADDR_DAY]  = to_bcd(s1_in_reg.mday);
        rec_data.bytes[ADDR_MON]  = to_bcd({3'd0, s1_in_reg.month})
                                  | (s1_upper_reg ? CENTURY_FLAG : 8'd0);
        rec_data.bytes[ADDR_YEAR] = to_bcd(s1_yy_reg);
    end

    assign rec_valid = s1_valid_reg;

endmodule

// ===== design/dtb_fifo.sv =====
module dtb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/dtb_back.sv =====
module dtb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rec_valid,
    output logic               rec_ready,
    input  dtb_pkg::dtb_rec_t  rec_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dtb_pkg::dtb_beat_t out_beat
);
    import dtb_pkg::*;

    logic      cur_valid_reg, cur_valid_next;
    dtb_rec_t  cur_reg, cur_next;
    logic [2:0] idx_reg, idx_next;
    logic      out_valid_reg, out_valid_next;
    dtb_beat_t out_reg, out_next;

    logic      load_out;
    logic      beat_last;

    // Emit one write per cycle while the output register is free
    assign load_out  = cur_valid_reg && (!out_valid_reg || out_ready);
    assign beat_last = cur_reg.err || (idx_reg == ADDR_YEAR);
    assign rec_ready = !cur_valid_reg || (load_out && beat_last);

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // Step through the bytes of the current item
        if (load_out) begin
            out_valid_next = 1'b1;
            if (cur_reg.err) begin
                out_next.reg_address = ADDR_SEC;
                out_next.reg_data    = 8'd0;
                out_next.status      = STATUS_ERR;
            end else begin
                out_next.reg_address = idx_reg;
                out_next.reg_data    = cur_reg.bytes[idx_reg];
                out_next.status      = STATUS_OK;
            end
            out_next.last = beat_last;
            idx_next      = idx_reg + 3'd1;
            if (beat_last) begin
                cur_valid_next = 1'b0;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        // Pull the next item from the queue
        if (rec_valid && rec_ready) begin
            cur_valid_next = 1'b1;
            cur_next       = rec_data;
            idx_next       = ADDR_SEC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= ADDR_SEC;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

// ===== design/datetime_to_bcd_rtc_registers.sv =====
// Date and time to clock-chip register writes. Each input transfer carries one
// calendar date and time; it is range checked (seconds and minutes 0-59, hours
// 0-24, day 1-31, month 1-12, year 2000-2199) and, if valid, turned into seven
// BCD register writes in address order: seconds, minutes, hours, weekday
// (1 = Sunday, from the Sakamoto table method), day, month (bit 7 set for
// years 2100 and later) and two-digit year, the final one marked by m_tlast.
// An invalid item gives a single transfer with m_tuser high, address and data
// zero and m_tlast high. The day is not checked against the month length. A
// front end with one register stage takes one input transfer per cycle into a
// queue of QUEUE_DEPTH items while its stage is empty or the queue has room;
// the output register sends one write per cycle while m_tready is high, and
// the output port sets the sustained rate. From input to output an item passes
// the front stage register, the queue, the current-item and output registers.
`include "datetime_to_bcd_rtc_registers_macros.svh"

module datetime_to_bcd_rtc_registers #(
    parameter int QUEUE_DEPTH = dtb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // seconds[6:0], minutes[13:7], hours[20:14], mday[27:21],
    // month[31:28], year[43:32], zero[47:44]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reg_address[2:0], reg_data[10:3], zero[15:11]
    output logic [15:0] m_tdata,
    // status[0]
    output logic        m_tuser,
    output logic        m_tlast
);
    import dtb_pkg::*;

    dtb_in_t   in_data;
    logic      q_in_valid, q_in_ready;
    dtb_rec_t  q_in_data;
    logic      q_out_valid, q_out_ready;
    dtb_rec_t  q_out_data;
    dtb_beat_t beat;

    logic [2:0] m_addr;
    logic [7:0] m_data;
    logic       err_beat;
    logic       ok_beat;

    assign in_data = s_tdata[43:0];

    // Check and encode
    dtb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_data),
        .rec_valid (q_in_valid),
        .rec_ready (q_in_ready),
        .rec_data  (q_in_data)
    );

    // Decouple front and back
    dtb_fifo #(
        .WIDTH ($bits(dtb_rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    // Serialize register writes
    dtb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_out_valid),
        .rec_ready (q_out_ready),
        .rec_data  (q_out_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (beat)
    );

    assign m_tdata = {5'd0, beat.reg_data, beat.reg_address};
    assign m_tuser = beat.status;
    assign m_tlast = beat.last;

    // Result fields seen by the checks
    assign m_addr   = m_tdata[2:0];
    assign m_data   = m_tdata[10:3];
    assign err_beat = m_tvalid && (m_tuser == STATUS_ERR);
    assign ok_beat  = m_tvalid && (m_tuser == STATUS_OK);

    `DTB_ASSERT_NOW(a_err_single, aclk, aresetn, err_beat,
        m_tlast && (m_addr == ADDR_SEC) && (m_data == 8'd0),
        "error result not a single zero beat")
    `DTB_ASSERT_NEXT(a_addr_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        m_tvalid && (m_addr == $past(m_addr) + 3'd1),
        "write sequence skipped or stalled")
    `DTB_ASSERT_NOW(a_last_at_year, aclk, aresetn, ok_beat,
        m_tlast == (m_addr == ADDR_YEAR),
        "last flag not on the year write")
    `DTB_ASSERT_NOW(a_wday_range, aclk, aresetn, ok_beat && (m_addr == ADDR_WDAY),
        (m_data >= 8'd1) && (m_data <= 8'd7),
        "weekday out of range")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 50;

    // One register write as seen on the result channel
    typedef struct packed {
        logic [2:0] addr;
        logic [7:0] data;
        logic       status;
        logic       last;
    } rtc_write_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // seconds[6:0], minutes[13:7], hours[20:14], mday[27:21],
    // month[31:28], year[43:32], zero[47:44]
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // reg_address[2:0], reg_data[10:3], zero[15:11]
    logic [15:0] m_tdata;
    // status[0]
    logic        m_tuser;
    logic        m_tlast;

    dtb_in_t    date_queue[$];
    rtc_write_t expected_writes[$];
    int         idle_pct  = 0;
    int         stall_pct = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    // Weekday table offsets for months 1..12, entry 0 unused
    int sakamoto_offset[16] = '{0, 0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4, 0, 0, 0};

    datetime_to_bcd_rtc_registers u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [7:0] two_digit_bcd(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Weekday 1..7, Sunday first; January and February count to the prior year
    function automatic int day_of_week(input int year, input int mon, input int day);
        int y;
        y = (mon < 3) ? year - 1 : year;
        return ((y + y / 4 - y / 100 + y / 400 + sakamoto_offset[mon] + day) % 7) + 1;
    endfunction

    // Queue the register writes that one accepted date should produce
    function automatic void predict_register_writes(input dtb_in_t d);
        logic [7:0] bytes[7];
        rtc_write_t w;
        logic       upper;
        int         yr;
        if (d.seconds > SEC_MAX || d.minutes > MIN_MAX || d.hours > HOUR_MAX ||
            d.mday < DAY_MIN || d.mday > DAY_MAX ||
            d.month < MON_MIN || d.month > MON_MAX ||
            d.year < YEAR_MIN || d.year > YEAR_MAX) begin
            w.addr   = ADDR_SEC;
            w.data   = 8'h00;
            w.status = STATUS_ERR;
            w.last   = 1'b1;
            expected_writes.push_back(w);
            return;
        end
        upper = (d.year >= YEAR_UPPER);
        yr    = upper ? int'(d.year) - int'(YEAR_UPPER) : int'(d.year) - int'(YEAR_MIN);
        bytes[ADDR_SEC]  = two_digit_bcd(d.seconds);
        bytes[ADDR_MIN]  = two_digit_bcd(d.minutes);
        bytes[ADDR_HOUR] = two_digit_bcd(d.hours);
        bytes[ADDR_WDAY] = two_digit_bcd(day_of_week(d.year, d.month, d.mday));
        bytes[ADDR_DAY]  = two_digit_bcd(d.mday);
        bytes[ADDR_MON]  = two_digit_bcd(d.month) | (upper ? CENTURY_FLAG : 8'h00);
        bytes[ADDR_YEAR] = two_digit_bcd(yr);
        for (int k = 0; k < NUM_REGS; k++) begin
            w.addr   = ADDR_SEC + 3'(k);
            w.data   = bytes[k];
            w.status = STATUS_OK;
            w.last   = (w.addr == ADDR_YEAR);
            expected_writes.push_back(w);
        end
    endfunction

    function automatic void add_date(input int sec, input int mins, input int hr,
                                     input int day, input int mon, input int yr);
        dtb_in_t d;
        d.seconds = 7'(sec);
        d.minutes = 7'(mins);
        d.hours   = 7'(hr);
        d.mday    = 7'(day);
        d.month   = 4'(mon);
        d.year    = 12'(yr);
        date_queue.push_back(d);
    endfunction

    // Mostly well-formed dates, some with one field out of range, some pure noise
    function automatic void add_random_date();
        dtb_in_t d;
        int      pick;
        pick = $urandom_range(99);
        d.seconds = 7'($urandom_range(SEC_MAX));
        d.minutes = 7'($urandom_range(MIN_MAX));
        d.hours   = 7'($urandom_range(HOUR_MAX));
        d.mday    = 7'($urandom_range(DAY_MAX, DAY_MIN));
        d.month   = 4'($urandom_range(MON_MAX, MON_MIN));
        d.year    = ($urandom_range(3) == 0) ?
                    12'($urandom_range(YEAR_UPPER + 1, YEAR_UPPER - 2)) :
                    12'($urandom_range(YEAR_MAX, YEAR_MIN));
        if (pick >= 90) begin
            d = dtb_in_t'($urandom());
            d.year = 12'($urandom());
        end else if (pick >= 75) begin
            case ($urandom_range(5))
                0: d.seconds      = 7'($urandom_range(127, SEC_MAX + 1));
                1: d.minutes      = 7'($urandom_range(127, MIN_MAX + 1));
                2: d.hours        = 7'($urandom_range(127, HOUR_MAX + 1));
                3: d.mday         = ($urandom_range(1) == 0) ? 7'd0 :
                                    7'($urandom_range(127, DAY_MAX + 1));
                4: d.month        = ($urandom_range(1) == 0) ? 4'd0 :
                                    4'($urandom_range(15, MON_MAX + 1));
                default: d.year   = ($urandom_range(1) == 0) ?
                                    12'($urandom_range(YEAR_MIN - 1)) :
                                    12'($urandom_range(4095, YEAR_MAX + 1));
            endcase
        end
        date_queue.push_back(d);
    endfunction

    // Source side: hold a transfer until accepted, predict on acceptance
    always @(posedge aclk) begin : drive_dates
        logic next_valid;
        next_valid = s_tvalid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_register_writes(dtb_in_t'(s_tdata[43:0]));
                next_valid = 1'b0;
            end
            if (!next_valid && date_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_tdata    <= {4'b0000, date_queue.pop_front()};
                next_valid = 1'b1;
            end
        end
        s_tvalid <= next_valid;
    end

    // Result side: random backpressure, compare each transfer with the oldest write
    always @(posedge aclk) begin : check_writes
        rtc_write_t got;
        rtc_write_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.addr   = m_tdata[2:0];
                got.data   = m_tdata[10:3];
                got.status = m_tuser;
                got.last   = m_tlast;
                if (expected_writes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected write: addr %0d data %h status %b last %b",
                                 got.addr, got.data, got.status, got.last);
                end else begin
                    want = expected_writes.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"write mismatch: expected addr %0d data %h status %b ",
                                      "last %b, got addr %0d data %h status %b last %b"},
                                     want.addr, want.data, want.status, want.last,
                                     got.addr, got.data, got.status, got.last);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (date_queue.size() != 0 || s_tvalid || expected_writes.size() != 0);
    endtask

    task automatic run_phase(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_date();
        // hold further dates until every write of this phase has come back
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: range edges, century boundary, leap handling, each invalid field
        add_date(0, 0, 0, 1, 1, 2000);
        add_date(59, 59, 24, 31, 12, 2199);
        add_date(59, 59, 23, 31, 12, 2099);
        add_date(0, 0, 0, 1, 1, 2100);
        add_date(12, 34, 12, 29, 2, 2000);
        add_date(1, 2, 3, 28, 2, 2100);
        add_date(30, 30, 10, 31, 2, 2101);
        add_date(45, 15, 6, 15, 3, 2024);
        add_date(7, 8, 9, 10, 11, 2150);
        add_date(60, 0, 0, 1, 1, 2000);
        add_date(0, 60, 0, 1, 1, 2000);
        add_date(0, 0, 25, 1, 1, 2000);
        add_date(0, 0, 0, 0, 1, 2000);
        add_date(0, 0, 0, 32, 1, 2000);
        add_date(0, 0, 0, 1, 0, 2000);
        add_date(0, 0, 0, 1, 13, 2000);
        add_date(0, 0, 0, 1, 15, 2000);
        add_date(0, 0, 0, 1, 1, 1999);
        add_date(0, 0, 0, 1, 1, 2200);
        add_date(127, 127, 127, 127, 15, 4095);
        add_date(0, 0, 0, 0, 0, 0);
        wait_idle();

        run_phase(0, 0);
        run_phase(48, 0);
        run_phase(0, 48);
        run_phase(37, 37);

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
